// File: design/service_registry_aging_table_macros.svh
// assertion macros for the service registry aging table
`ifndef SERVICE_REGISTRY_AGING_TABLE_MACROS_SVH
`define SERVICE_REGISTRY_AGING_TABLE_MACROS_SVH

// same-cycle implication, checked while out of reset
`define SRAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define SRAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/srat_pkg.sv
// shared constants for the service registry aging table
package srat_pkg;

  localparam int unsigned DefEntries  = 16;
  localparam logic [15:0] DefLifetime = 16'd600;

  localparam logic [1:0] FN_LOCAL  = 2'd0;
  localparam logic [1:0] FN_REMOTE = 2'd1;
  localparam logic [1:0] FN_LOOKUP = 2'd2;
  localparam logic [1:0] FN_TICK   = 2'd3;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_REFRESHED = 3'd1;
  localparam logic [2:0] ST_UNCHANGED = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_FOUND     = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_TICK      = 3'd6;

  // per-entry metadata kept in the table memory
  typedef struct packed {
    logic        is_local;
    logic [7:0]  service;
    logic [7:0]  seqno;
    logic [15:0] life;
  } meta_t;

  localparam int unsigned MetaW = $bits(meta_t);

endpackage

// File: design/srat_req_if.sv
// request channel: one registry operation
interface srat_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  service_id;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [7:0]  record_seqno;

  modport source (output valid, func, service_id, addr_high, addr_low, record_seqno,
                  input ready);
  modport sink (input valid, func, service_id, addr_high, addr_low, record_seqno,
                output ready);
endinterface

// File: design/srat_rsp_if.sv
// response channel: status and found address
interface srat_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] found_addr_high;
  logic [63:0] found_addr_low;

  modport source (output valid, status, found_addr_high, found_addr_low, input ready);
  modport sink (input valid, status, found_addr_high, found_addr_low, output ready);
endinterface

// File: design/srat_ram.sv
// generic single-write, single-read ram with registered read
module srat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: design/service_registry_aging_table.sv
// service registry aging table: top level
//
//  channel | dir | handshake   | carries
//  --------+-----+-------------+------------------------------------------------
//  req_i   | in  | valid/ready | func, service_id, addr_high/low, record_seqno
//  rsp_o   | out | valid/ready | status, found_addr_high/low
//  cfg     | in  | write only  | lifetime_ticks
//
// every request scans the metadata memory once, one entry a cycle, then passes through
// act and done, whatever the function; done loads the result into the output register
// and returns to idle, where the next request is taken
// the scan and the single metadata read port set the pace of requests
// reset clears the used bits held in flops; memories need no clearing pass
// a new request is taken only when idle; a result waits in the output register
// until taken and the next request may enter meanwhile
module service_registry_aging_table #(
  parameter int unsigned ENTRIES = srat_pkg::DefEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  srat_req_if.sink    req_i,
  srat_rsp_if.source  rsp_o
);
  `include "service_registry_aging_table_macros.svh"

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ACT, S_DONE} state_e;

  state_e              state_q;
  logic [15:0]         life_cfg_q;
  logic [ENTRIES-1:0]  used_q, used_d;

  // captured request
  logic [1:0]   func_q;
  logic [7:0]   id_q;
  logic [63:0]  ahi_q, alo_q;
  logic [7:0]   rseq_q;

  // scan bookkeeping
  logic [CW-1:0] cnt_q;
  logic          pv_q;          // metadata read data valid this cycle
  logic [IW-1:0] pidx_q;        // entry whose data is on the read port
  logic          hit_q, free_q;
  logic [IW-1:0] hit_idx_q, free_idx_q;
  logic [7:0]    hit_seq_q;
  logic          found_q;

  // output register
  logic          ovld_q;
  logic [2:0]    ostat_q, res_d;
  logic [63:0]   ohi_q, olo_q;

  // memory ports
  logic                 m_we, m_re, a_we, a_re;
  logic [IW-1:0]        m_waddr, m_raddr, a_raddr;
  srat_pkg::meta_t      m_wdata, m_rdata;
  logic [127:0]         a_rdata;

  srat_ram #(.Width(srat_pkg::MetaW), .Depth(ENTRIES)) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (m_we),
    .waddr_i(m_waddr),
    .wdata_i(m_wdata),
    .re_i   (m_re),
    .raddr_i(m_raddr),
    .rdata_o(m_rdata)
  );

  srat_ram #(.Width(128), .Depth(ENTRIES)) u_addr_ram (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(free_idx_q),
    .wdata_i({ahi_q, alo_q}),
    .re_i   (a_re),
    .raddr_i(a_raddr),
    .rdata_o(a_rdata)
  );

  logic        req_fire, scan_issue, last_done, p_used, p_match, want_local;
  logic [15:0] life_dec, half_life;
  logic [7:0]  seq_diff;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign scan_issue  = (state_q == S_SCAN) && (cnt_q != CW'(ENTRIES));
  assign last_done   = (state_q == S_SCAN) && !scan_issue;
  assign half_life   = {1'b0, life_cfg_q[15:1]};
  assign want_local  = (func_q == srat_pkg::FN_LOCAL);
  assign p_used      = used_q[pidx_q];
  assign p_match     = p_used && (m_rdata.is_local == want_local) &&
                       (m_rdata.service == id_q);
  assign life_dec    = (m_rdata.life == 16'd0) ? 16'd0 : m_rdata.life - 16'd1;
  assign seq_diff    = hit_seq_q - rseq_q;

  assign m_re    = scan_issue;
  assign m_raddr = cnt_q[IW-1:0];

  // write side and address read: aging during the scan, allocation, refresh or lookup read afterwards
  always_comb begin
    m_we    = 1'b0;
    m_waddr = pidx_q;
    m_wdata = m_rdata;
    a_we    = 1'b0;
    a_re    = 1'b0;
    a_raddr = hit_idx_q;
    used_d  = used_q;
    res_d   = srat_pkg::ST_TICK;
    if (state_q == S_SCAN && pv_q && func_q == srat_pkg::FN_TICK && p_used) begin
      m_we = 1'b1;
      m_wdata.life = life_dec;
      if (life_dec == 16'd0) begin
        if (m_rdata.is_local) begin
          m_wdata.seqno = m_rdata.seqno + 8'd1;
          m_wdata.life  = half_life;
        end else begin
          used_d[pidx_q] = 1'b0;
        end
      end
    end
    if (state_q == S_ACT) begin
      unique case (func_q)
        srat_pkg::FN_LOCAL, srat_pkg::FN_REMOTE: begin
          if (hit_q && want_local) begin
            res_d = srat_pkg::ST_UNCHANGED;
          end else if (hit_q) begin
            if (seq_diff[7]) begin
              res_d   = srat_pkg::ST_REFRESHED;
              m_we    = 1'b1;
              m_waddr = hit_idx_q;
              m_wdata = '{is_local: 1'b0, service: id_q, seqno: rseq_q, life: life_cfg_q};
            end else begin
              res_d = srat_pkg::ST_UNCHANGED;
            end
          end else if (free_q) begin
            res_d   = srat_pkg::ST_ADDED;
            m_we    = 1'b1;
            a_we    = 1'b1;
            m_waddr = free_idx_q;
            m_wdata = '{is_local: want_local, service: id_q, seqno: 8'd1,
                        life: want_local ? half_life : life_cfg_q};
            used_d[free_idx_q] = 1'b1;
          end else begin
            res_d = srat_pkg::ST_FULL;
          end
        end
        srat_pkg::FN_LOOKUP: begin
          a_re  = hit_q;
          res_d = hit_q ? srat_pkg::ST_FOUND : srat_pkg::ST_NOT_FOUND;
        end
        default: res_d = srat_pkg::ST_TICK;
      endcase
    end
  end

  logic [2:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      life_cfg_q <= srat_pkg::DefLifetime;
      used_q     <= '0;
      cnt_q      <= '0;
      pv_q       <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      found_q    <= 1'b0;
      ovld_q     <= 1'b0;
      res_q      <= srat_pkg::ST_TICK;
    end else begin
      if (cfg_we_i) begin
        life_cfg_q <= cfg_wdata_i;
      end
      used_q <= used_d;
      // in done the output register is only ever loaded, never emptied
      if (rsp_o.ready && state_q != S_DONE) begin
        ovld_q <= 1'b0;
      end
      pv_q   <= scan_issue;
      pidx_q <= cnt_q[IW-1:0];
      if (scan_issue) begin
        cnt_q <= cnt_q + CW'(1);
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            func_q  <= req_i.func;
            id_q    <= req_i.service_id;
            ahi_q   <= req_i.addr_high;
            alo_q   <= req_i.addr_low;
            rseq_q  <= req_i.record_seqno;
            cnt_q   <= '0;
            hit_q   <= 1'b0;
            free_q  <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (pv_q) begin
            if (p_match && !hit_q) begin
              hit_q     <= 1'b1;
              hit_idx_q <= pidx_q;
              hit_seq_q <= m_rdata.seqno;
            end
            if (!p_used && !free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= pidx_q;
            end
          end
          if (last_done && !pv_q) begin
            state_q <= S_ACT;
          end
        end
        S_ACT: begin
          res_q   <= res_d;
          found_q <= (res_d == srat_pkg::ST_FOUND);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!ovld_q || rsp_o.ready) begin
            ovld_q  <= 1'b1;
            ostat_q <= res_q;
            ohi_q   <= found_q ? a_rdata[127:64] : 64'd0;
            olo_q   <= found_q ? a_rdata[63:0] : 64'd0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid           = ovld_q;
  assign rsp_o.status          = ostat_q;
  assign rsp_o.found_addr_high = ohi_q;
  assign rsp_o.found_addr_low  = olo_q;

  `SRAT_ASSERT_NEXT(a_fire_scan, req_fire, state_q == S_SCAN, "request did not start scan")
  `SRAT_ASSERT_NOW(a_no_rw_clash, m_we && m_re, m_waddr != m_raddr, "meta ram read/write clash")
  `SRAT_ASSERT_NOW(a_stat_range, ovld_q, ostat_q <= srat_pkg::ST_TICK, "status out of range")
  `SRAT_ASSERT_NOW(a_act_no_read, state_q == S_ACT, !m_re, "scan read outside scan")
endmodule

// File: dv/service_registry_aging_table_tb.sv
// testbench for the service registry aging table: directed and random requests against a predictor
module service_registry_aging_table_tb;

  localparam int unsigned Slots      = srat_pkg::DefEntries;
  localparam int unsigned DrainWait  = Slots + 16;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandItems  = 950;
  localparam int unsigned HoldCycles = 300;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  id;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  seq;
    bit          typed;   // status below is known up front
    logic [2:0]  status;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [63:0] fh;
    logic [63:0] fl;
  } result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;

  srat_req_if req_if();
  srat_rsp_if rsp_if();

  service_registry_aging_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // shadow copy of the table and the lifetime register
  logic        tbl_used  [Slots];
  logic        tbl_local [Slots];
  logic [7:0]  tbl_svc   [Slots];
  logic [63:0] tbl_hi    [Slots];
  logic [63:0] tbl_lo    [Slots];
  logic [7:0]  tbl_seq   [Slots];
  logic [15:0] tbl_life  [Slots];
  logic [15:0] life_full;

  result_t     pending_results[$];
  int          errors;
  int unsigned cycles;
  bit          no_idle;     // stretch with no idling on either side
  bit          hold_rsp;    // asks the response side for one long hold-off

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // lowest-index used slot of the given kind with this id, Slots if none
  function automatic int find_entry(logic is_local, logic [7:0] id);
    for (int i = 0; i < Slots; i++) begin
      if (tbl_used[i] && tbl_local[i] == is_local && tbl_svc[i] == id) return i;
    end
    return Slots;
  endfunction

  function automatic logic [2:0] claim_entry(logic is_local, request_t r, logic [15:0] life);
    for (int i = 0; i < Slots; i++) begin
      if (!tbl_used[i]) begin
        tbl_used[i]  = 1'b1;
        tbl_local[i] = is_local;
        tbl_svc[i]   = r.id;
        tbl_hi[i]    = r.hi;
        tbl_lo[i]    = r.lo;
        tbl_seq[i]   = 8'd1;
        tbl_life[i]  = life;
        return srat_pkg::ST_ADDED;
      end
    end
    return srat_pkg::ST_FULL;
  endfunction

  // applies one request to the shadow table and returns its result
  function automatic result_t registry_step(request_t r);
    result_t res;
    int      idx;
    res = '{status: srat_pkg::ST_TICK, fh: '0, fl: '0};
    case (r.func)
      srat_pkg::FN_LOCAL: begin
        if (find_entry(1'b1, r.id) < Slots) res.status = srat_pkg::ST_UNCHANGED;
        else res.status = claim_entry(1'b1, r, life_full >> 1);
      end
      srat_pkg::FN_REMOTE: begin
        idx = find_entry(1'b0, r.id);
        if (idx < Slots) begin
          // serial comparison: newer when stored minus incoming wraps to 128 or more
          if (8'(tbl_seq[idx] - r.seq) >= 8'd128) begin
            tbl_seq[idx]  = r.seq;
            tbl_life[idx] = life_full;
            res.status    = srat_pkg::ST_REFRESHED;
          end else begin
            res.status = srat_pkg::ST_UNCHANGED;
          end
        end else begin
          res.status = claim_entry(1'b0, r, life_full);
        end
      end
      srat_pkg::FN_LOOKUP: begin
        idx = find_entry(1'b0, r.id);
        if (idx < Slots) begin
          res = '{status: srat_pkg::ST_FOUND, fh: tbl_hi[idx], fl: tbl_lo[idx]};
        end else begin
          res.status = srat_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        for (int i = 0; i < Slots; i++) begin
          if (tbl_used[i]) begin
            if (tbl_life[i] != 16'd0) tbl_life[i] = tbl_life[i] - 16'd1;
            if (tbl_life[i] == 16'd0) begin
              if (tbl_local[i]) begin
                tbl_seq[i]  = tbl_seq[i] + 8'd1;
                tbl_life[i] = life_full >> 1;
              end else begin
                tbl_used[i] = 1'b0;
                tbl_svc[i]  = '0;
                tbl_seq[i]  = '0;
              end
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  // offers one request and waits for it to be taken; valid stays up when no gap follows
  task automatic send_request(request_t r);
    int      gap;
    result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.func         <= r.func;
    req_if.service_id   <= r.id;
    req_if.addr_high    <= r.hi;
    req_if.addr_low     <= r.lo;
    req_if.record_seqno <= r.seq;
    do @(posedge clk_i); while (!req_if.ready);
    res = registry_step(r);
    if (r.typed) res = '{status: r.status, fh: '0, fl: '0};
    pending_results.push_back(res);
  endtask

  // lets every outstanding request finish, then a little more for the scan
  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_lifetime(logic [15:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    life_full = value;
    cfg_we_i <= 1'b0;
  endtask

  // random request: small id pool so entries get hit, full range now and then
  function automatic request_t random_request();
    request_t r;
    int       pick;
    pick    = $urandom_range(0, 99);
    r.func  = pick < 15 ? srat_pkg::FN_LOCAL : pick < 45 ? srat_pkg::FN_REMOTE :
              pick < 70 ? srat_pkg::FN_LOOKUP : srat_pkg::FN_TICK;
    r.id    = $urandom_range(0, 9) < 8 ? 8'($urandom_range(0, 7)) : 8'($urandom);
    r.hi    = {$urandom, $urandom};
    r.lo    = {$urandom, $urandom};
    r.seq   = 8'($urandom);
    r.typed = 1'b0;
    r.status = '0;
    return r;
  endfunction

  // directed rows, lifetime at its reset value
  request_t opening_rows[] = '{
    '{srat_pkg::FN_LOOKUP, 8'd5,   '0, '0, 8'd0,   1, srat_pkg::ST_NOT_FOUND},  // empty
    '{srat_pkg::FN_TICK,   8'd0,   '0, '0, 8'd0,   1, srat_pkg::ST_TICK},
    '{srat_pkg::FN_LOCAL,  8'd0,   '1, '0, 8'd0,   1, srat_pkg::ST_ADDED},
    '{srat_pkg::FN_LOCAL,  8'd0,   '0, '1, 8'd255, 1, srat_pkg::ST_UNCHANGED},  // dup local
    '{srat_pkg::FN_REMOTE, 8'd255, '0, '1, 8'd200, 1, srat_pkg::ST_ADDED},      // seqno 1
    '{srat_pkg::FN_LOOKUP, 8'd255, '0, '0, 8'd0,   0, srat_pkg::ST_ADDED},
    '{srat_pkg::FN_REMOTE, 8'd255, '1, '0, 8'd0,   1, srat_pkg::ST_UNCHANGED},  // stale
    '{srat_pkg::FN_REMOTE, 8'd255, '1, '1, 8'd2,   1, srat_pkg::ST_REFRESHED},  // addr kept
    '{srat_pkg::FN_REMOTE, 8'd255, '0, '0, 8'd130, 0, srat_pkg::ST_ADDED},      // diff 128
    '{srat_pkg::FN_REMOTE, 8'd255, '0, '0, 8'd130, 0, srat_pkg::ST_ADDED},      // same seqno
    '{srat_pkg::FN_LOOKUP, 8'd255, '0, '0, 8'd0,   0, srat_pkg::ST_ADDED},
    '{srat_pkg::FN_LOOKUP, 8'd0,   '0, '0, 8'd0,   1, srat_pkg::ST_NOT_FOUND}   // skip local
  };

  logic [15:0] phase_life[] = '{16'd2, 16'd65535, 16'd3, 16'd1, 16'd0, 16'd9, 16'd5};

  // response side: random stalls, one long hold-off when asked
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rsp = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d", $time, rsp_if.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, rsp_if.status);
          errors++;
        end
        if (rsp_if.found_addr_high !== want.fh) begin
          $display("%0t: found_addr_high expected %h got %h", $time, want.fh,
                   rsp_if.found_addr_high);
          errors++;
        end
        if (rsp_if.found_addr_low !== want.fl) begin
          $display("%0t: found_addr_low expected %h got %h", $time, want.fl,
                   rsp_if.found_addr_low);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    request_t r;
    errors   = 0;
    cycles   = 0;
    no_idle  = 1'b0;
    hold_rsp = 1'b0;
    life_full = srat_pkg::DefLifetime;
    for (int i = 0; i < Slots; i++) begin
      tbl_used[i] = 1'b0; tbl_local[i] = 1'b0; tbl_svc[i] = '0;
      tbl_hi[i] = '0; tbl_lo[i] = '0; tbl_seq[i] = '0; tbl_life[i] = '0;
    end
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    req_if.valid <= 1'b0;
    req_if.func  <= srat_pkg::FN_TICK;
    req_if.service_id   <= '0;
    req_if.addr_high    <= '0;
    req_if.addr_low     <= '0;
    req_if.record_seqno <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_rows[i]) send_request(opening_rows[i]);

    // fill the table with short-lived remotes, then hit the full case both ways
    write_lifetime(16'd2);
    for (int id = 1; id <= Slots - 2; id++) begin
      r = '{srat_pkg::FN_REMOTE, 8'(id), {$urandom, $urandom}, {$urandom, $urandom},
            8'($urandom), 0, 0};
      send_request(r);
    end
    send_request('{srat_pkg::FN_REMOTE, 8'd100, '1, '1, 8'd7, 1, srat_pkg::ST_FULL});
    send_request('{srat_pkg::FN_LOCAL,  8'd101, '1, '1, 8'd7, 1, srat_pkg::ST_FULL});
    send_request('{srat_pkg::FN_TICK, 8'd0, '0, '0, 8'd0, 1, srat_pkg::ST_TICK});
    send_request('{srat_pkg::FN_TICK, 8'd0, '0, '0, 8'd0, 1, srat_pkg::ST_TICK});

    // random phases over a range of lifetimes
    for (int n = 0; n < RandItems; n++) begin
      if (n % (RandItems / $size(phase_life) + 1) == 0)
        write_lifetime(phase_life[n / (RandItems / $size(phase_life) + 1)]);
      if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n == 300) hold_rsp = 1'b1;   // response side stalls long, requests back up
      if (n == 600) drain();           // request side waits out every result
      send_request(random_request());
    end

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/srat_pkg.sv
design/srat_req_if.sv
design/srat_rsp_if.sv
design/srat_ram.sv
design/service_registry_aging_table.sv
dv/service_registry_aging_table_tb.sv
